FILE: rtl/mhbm_pkg.sv
// ----------------------------------------------------------------------------
// mhbm_pkg
// Shared types and constants for the masked Hamming best-match core.
// ----------------------------------------------------------------------------
package mhbm_pkg;

  localparam int WORD_BITS   = 64;
  localparam int DIST_BITS   = 10;
  localparam int MSUM_BITS   = 14;
  localparam int THR_BITS    = 14;
  localparam int INDEX_BITS  = 16;
  localparam int OUT_IDX_BITS = 16;
  localparam int PROD_BITS   = DIST_BITS + MSUM_BITS;
  localparam int NUM_BITS    = PROD_BITS + 1;
  localparam int DEN_BITS    = MSUM_BITS + 1;
  localparam int QDEPTH      = 2;
  localparam int QPTR_BITS   = 1;
  localparam int QCNT_BITS   = 2;

  localparam logic [DIST_BITS-1:0] DIST_SAT      = '1;
  localparam logic [MSUM_BITS-1:0] MSUM_SAT      = '1;
  localparam logic [THR_BITS-1:0]  NO_MATCH_DIST = THR_BITS'(10000);

  // One finished candidate, handed from front to back.
  typedef struct packed {
    logic [DIST_BITS-1:0] dist_l;
    logic [DIST_BITS-1:0] dist_r;
    logic [MSUM_BITS-1:0] msum_l;
    logic [MSUM_BITS-1:0] msum_r;
    logic                 last_cand;
  } job_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [6:0] pop64(input logic [WORD_BITS-1:0] v);
    logic [6:0] s;
    s = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      s = s + 7'(v[i]);
    end
    return s;
  endfunction

  function automatic logic [10:0] byte_sum(input logic [WORD_BITS-1:0] v);
    logic [10:0] s;
    s = '0;
    for (int k = 0; k < WORD_BITS / 8; k++) begin
      s = s + 11'(v[8*k +: 8]);
    end
    return s;
  endfunction

endpackage

FILE: rtl/mhbm_front.sv
// ----------------------------------------------------------------------------
// mhbm_front
// Accepts word beats, accumulates masked popcounts and mask sums per
// candidate and pushes one job per candidate into the queue.
// ----------------------------------------------------------------------------
module mhbm_front import mhbm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_BITS-1:0] query_word,
  input  logic [WORD_BITS-1:0] query_mask_word,
  input  logic [WORD_BITS-1:0] candidate_word,
  input  logic [WORD_BITS-1:0] candidate_mask_word,
  input  logic                 last_word,
  input  logic                 last_candidate,
  input  q_status_t            q_status,
  output logic                 push,
  output job_t                 push_job
);

  logic [DIST_BITS-1:0] dist_l, dist_r;
  logic [MSUM_BITS-1:0] msum_l, msum_r;
  logic [DIST_BITS-1:0] dist_l_next, dist_r_next;
  logic [MSUM_BITS-1:0] msum_l_next, msum_r_next;
  logic [WORD_BITS-1:0] diff;
  logic [DIST_BITS:0]   sum_dl, sum_dr;
  logic [MSUM_BITS:0]   sum_ml, sum_mr;
  logic                 accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign diff     = query_word ^ candidate_word;

  always_comb begin
    sum_dl = {1'b0, dist_l} + (DIST_BITS+1)'(pop64(diff & query_mask_word));
    sum_dr = {1'b0, dist_r} + (DIST_BITS+1)'(pop64(diff & candidate_mask_word));
    sum_ml = {1'b0, msum_l} + (MSUM_BITS+1)'(byte_sum(query_mask_word));
    sum_mr = {1'b0, msum_r} + (MSUM_BITS+1)'(byte_sum(candidate_mask_word));
    dist_l_next = sum_dl[DIST_BITS] ? DIST_SAT : sum_dl[DIST_BITS-1:0];
    dist_r_next = sum_dr[DIST_BITS] ? DIST_SAT : sum_dr[DIST_BITS-1:0];
    msum_l_next = sum_ml[MSUM_BITS] ? MSUM_SAT : sum_ml[MSUM_BITS-1:0];
    msum_r_next = sum_mr[MSUM_BITS] ? MSUM_SAT : sum_mr[MSUM_BITS-1:0];
  end

  assign push               = accept && last_word;
  assign push_job.dist_l    = dist_l_next;
  assign push_job.dist_r    = dist_r_next;
  assign push_job.msum_l    = msum_l_next;
  assign push_job.msum_r    = msum_r_next;
  assign push_job.last_cand = last_candidate;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      dist_l <= '0;
      dist_r <= '0;
      msum_l <= '0;
      msum_r <= '0;
    end else if (accept) begin
      dist_l <= dist_l_next;
      dist_r <= dist_r_next;
      msum_l <= msum_l_next;
      msum_r <= msum_r_next;
    end
  end

endmodule

FILE: rtl/mhbm_queue.sv
// ----------------------------------------------------------------------------
// mhbm_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module mhbm_queue import mhbm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      pop_job,
  output q_status_t q_status
);

  job_t                 slots [QDEPTH];
  logic [QPTR_BITS-1:0] wptr, rptr;
  logic [QCNT_BITS-1:0] count;

  assign q_status.full  = (count == QCNT_BITS'(QDEPTH));
  assign q_status.empty = (count == '0);
  assign pop_job        = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/mhbm_back.sv
// ----------------------------------------------------------------------------
// mhbm_back
// Weighted distance per candidate (two products, restoring divider), best
// match tracking and the result register.
// ----------------------------------------------------------------------------
module mhbm_back import mhbm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [THR_BITS-1:0]     threshold,
  input  q_status_t               q_status,
  input  job_t                    pop_job,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    found,
  output logic [OUT_IDX_BITS-1:0] best_index,
  output logic [THR_BITS-1:0]     best_distance
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MUL    = 5'b00010,
    S_SUM    = 5'b00100,
    S_DIV    = 5'b01000,
    S_DECIDE = 5'b10000
  } state_t;

  state_t                state;
  job_t                  job;
  logic [PROD_BITS-1:0]  prod_l, prod_r;
  logic [DEN_BITS-1:0]   den;
  logic [NUM_BITS-1:0]   rem;
  logic [DIST_BITS-1:0]  quo;
  logic [3:0]            step;
  logic [NUM_BITS-1:0]   trial;
  logic [DIST_BITS-1:0]  cand_dist;
  logic [THR_BITS-1:0]   thr_eff;
  logic                  better;
  logic [THR_BITS-1:0]   best_so_far;
  logic [INDEX_BITS-1:0] best_slot;
  logic                  hit_flag;
  logic [INDEX_BITS-1:0] cand_count;
  logic                  can_decide;
  logic [THR_BITS-1:0]   best_next;
  logic [INDEX_BITS-1:0] slot_next;
  logic                  hit_next;

  assign pop       = (state == S_IDLE) && !q_status.empty;
  assign trial     = NUM_BITS'(den) << step;
  assign cand_dist = (den == '0) ? '0 : quo;
  assign thr_eff   = (threshold == '0) ? NO_MATCH_DIST : threshold;
  assign better    = (THR_BITS'(cand_dist) < best_so_far) &&
                     (THR_BITS'(cand_dist) < thr_eff);
  assign can_decide = !job.last_cand || !out_valid || !out_stall;

  always_comb begin
    best_next = better ? THR_BITS'(cand_dist) : best_so_far;
    slot_next = better ? cand_count : best_slot;
    hit_next  = better || hit_flag;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= pop_job;
    end
    if (state == S_MUL) begin
      prod_l <= PROD_BITS'(job.dist_l) * PROD_BITS'(job.msum_l);
      prod_r <= PROD_BITS'(job.dist_r) * PROD_BITS'(job.msum_r);
      den    <= DEN_BITS'(job.msum_l) + DEN_BITS'(job.msum_r);
    end
    if (state == S_SUM) begin
      rem <= NUM_BITS'(prod_l) + NUM_BITS'(prod_r);
      quo <= '0;
    end
    if (state == S_DIV) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        quo <= quo | (DIST_BITS'(1) << step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      step        <= '0;
      best_so_far <= NO_MATCH_DIST;
      best_slot   <= '0;
      hit_flag    <= 1'b0;
      cand_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if ((state == S_DECIDE) && can_decide && job.last_cand) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_SUM;
        end
        S_SUM: begin
          step  <= 4'(DIST_BITS - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          if (step == '0) begin
            state <= S_DECIDE;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_DECIDE: begin
          if (can_decide) begin
            if (job.last_cand) begin
              found         <= hit_next;
              best_index    <= OUT_IDX_BITS'(slot_next);
              best_distance <= best_next;
              best_so_far   <= NO_MATCH_DIST;
              best_slot     <= '0;
              hit_flag      <= 1'b0;
              cand_count    <= '0;
            end else begin
              cand_count  <= cand_count + 1'b1;
              best_so_far <= best_next;
              best_slot   <= slot_next;
              hit_flag    <= hit_next;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/masked_hamming_best_match_core.sv
// Front: one word beat per cycle while the job queue is not full (in_stall); a
// candidate leaves as one job at its last word. Back: one candidate at a time
// (multiply, sum, 10-step restoring divider, decide). The result for the last
// candidate follows once every candidate queued or in progress ahead of it is done.
// Synchronous active-high reset clears accumulators, best match state, the
// job queue, the result valid flag and the threshold (0 selects 10000).
// ----------------------------------------------------------------------------
// masked_hamming_best_match_core
// Top level: threshold register, front accumulator, job queue and back end.
// ----------------------------------------------------------------------------
module masked_hamming_best_match_core import mhbm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [THR_BITS-1:0]     cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [WORD_BITS-1:0]    query_word,
  input  logic [WORD_BITS-1:0]    query_mask_word,
  input  logic [WORD_BITS-1:0]    candidate_word,
  input  logic [WORD_BITS-1:0]    candidate_mask_word,
  input  logic                    last_word,
  input  logic                    last_candidate,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    found,
  output logic [OUT_IDX_BITS-1:0] best_index,
  output logic [THR_BITS-1:0]     best_distance
);

  logic [THR_BITS-1:0] threshold;
  q_status_t           q_status;
  logic                push, pop;
  job_t                push_job, pop_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_write) begin
      threshold <= cfg_data;
    end
  end

  mhbm_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .query_word          (query_word),
    .query_mask_word     (query_mask_word),
    .candidate_word      (candidate_word),
    .candidate_mask_word (candidate_mask_word),
    .last_word           (last_word),
    .last_candidate      (last_candidate),
    .q_status            (q_status),
    .push                (push),
    .push_job            (push_job)
  );

  mhbm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_status (q_status)
  );

  mhbm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .threshold     (threshold),
    .q_status      (q_status),
    .pop_job       (pop_job),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .best_index    (best_index),
    .best_distance (best_distance)
  );

endmodule
